// ----- hw/rtl/hrfl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrfl_pkg
// Shared types and constants of the hex record flash loader.
// ----------------------------------------------------------------------------
package hrfl_pkg;

  // default of the largest data length that is buffered
  localparam int MAX_DATA_BYTES_DEF = 255;

  // word index within one record, wide enough for the largest legal length
  localparam int LAST_IDX_W = 6;

  // configuration port
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // register indexes
  localparam logic [2:0] REG_ALLOW_LOW    = 3'd0;
  localparam logic [2:0] REG_ALLOW_HIGH   = 3'd1;
  localparam logic [2:0] REG_PROTECT_LOW  = 3'd2;
  localparam logic [2:0] REG_PROTECT_HIGH = 3'd3;
  localparam logic [2:0] REG_RESERVE_LOW  = 3'd4;
  localparam logic [2:0] REG_RESERVE_HIGH = 3'd5;

  // register reset values
  localparam logic [31:0] ALLOW_LOW_RST    = 32'h9D00_0000;
  localparam logic [31:0] ALLOW_HIGH_RST   = 32'h9D07_FFFF;
  localparam logic [31:0] PROTECT_LOW_RST  = 32'h9FC0_2FF0;
  localparam logic [31:0] PROTECT_HIGH_RST = 32'h9FC0_2FFF;
  localparam logic [31:0] RESERVE_LOW_RST  = 32'hFFFF_FFFF;
  localparam logic [31:0] RESERVE_HIGH_RST = 32'h0000_0000;

  // kseg0 mapping bit
  localparam logic [31:0] KSEG0_BIT = 32'h8000_0000;

  // record types
  localparam logic [7:0] REC_DATA    = 8'h00;
  localparam logic [7:0] REC_EXT_SEG = 8'h02;
  localparam logic [7:0] REC_EXT_LIN = 8'h04;

  // result kinds
  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_SKIP   = 2'd1,
    KIND_ACCEPT = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  // address filter windows
  typedef struct packed {
    logic [31:0] allow_low;
    logic [31:0] allow_high;
    logic [31:0] protect_low;
    logic [31:0] protect_high;
    logic [31:0] reserve_low;
    logic [31:0] reserve_high;
  } cfg_t;

  // finished record handed from front to back
  typedef struct packed {
    logic                  is_data;
    kind_e                 kind;
    logic                  bank;
    logic [31:0]           base;
    logic [LAST_IDX_W-1:0] last_idx;
  } desc_t;

  // bank release from back to front
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  // one result item
  typedef struct packed {
    kind_e       kind;
    logic [31:0] addr;
    logic [31:0] data;
    logic        last;
  } res_t;

endpackage
`default_nettype wire

// ----- hw/rtl/hrfl_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrfl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hrfl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output      logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds while idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/hrfl_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrfl_fifo
// Short register queue with full and empty flags.
// ----------------------------------------------------------------------------
module hrfl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output      logic             full_o,
  input  wire logic             pop_i,
  output      logic [WIDTH-1:0] rdata_o,
  output      logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/hrfl_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrfl_front
// Frames records by length, checks the sum, packs data words into the
// current bank and hands a record descriptor to the back end.
// ----------------------------------------------------------------------------
module hrfl_front #(
  parameter int MAX_DATA_BYTES = hrfl_pkg::MAX_DATA_BYTES_DEF,
  parameter int WPB            = (MAX_DATA_BYTES + 3) / 4,
  parameter int AW             = $clog2(2 * WPB)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  output      logic                full_o,
  input  wire logic [7:0]          rec_byte_i,
  input  wire logic                buffer_last_i,
  output      logic                ram_we_o,
  output      logic [AW-1:0]       ram_waddr_o,
  output      logic [31:0]         ram_wdata_o,
  output      logic                q_push_o,
  output      hrfl_pkg::desc_t     q_desc_o,
  input  wire logic                q_full_i,
  input  wire hrfl_pkg::rel_t      rel_i
);

  import hrfl_pkg::*;

  logic [8:0]  byte_idx_q, byte_idx_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  type_q;
  logic [15:0] off_q;
  logic [15:0] adat_q;
  logic [31:0] word_q;
  logic [31:0] base_hi_q, base_hi_d;
  logic        bank_q, bank_d;
  logic [1:0]  busy_q, busy_d;

  logic        acc, idx0, done, err, is_data, store;
  logic [8:0]  idx_inc, pos;
  logic [31:0] word_nxt;
  logic [7:0]  len_m1;

  assign acc    = push_i && !full_o;
  assign full_o = q_full_i || busy_q[bank_q];

  // framing arithmetic for the byte on the input
  always_comb begin
    idx0    = (byte_idx_q == 9'd0);
    len_d   = idx0 ? rec_byte_i : len_q;
    sum_d   = (idx0 ? 8'd0 : sum_q) + rec_byte_i;
    idx_inc = byte_idx_q + 9'd1;
    done    = (idx_inc == ({1'b0, len_d} + 9'd5));
    pos     = byte_idx_q - 9'd4;
    is_data = (byte_idx_q >= 9'd4) && (pos < {1'b0, len_d});
    store   = is_data && (pos < 9'(MAX_DATA_BYTES));
    err     = ({1'b0, len_d} > 9'(MAX_DATA_BYTES)) || (sum_d != 8'd0);
    len_m1  = len_d - 8'd1;
  end

  // word packing, unused lanes stay 0xFF
  always_comb begin
    word_nxt = (pos[1:0] == 2'd0) ? 32'hFFFF_FFFF : word_q;
    case (pos[1:0])
      2'd0:    word_nxt[7:0]   = rec_byte_i;
      2'd1:    word_nxt[15:8]  = rec_byte_i;
      2'd2:    word_nxt[23:16] = rec_byte_i;
      2'd3:    word_nxt[31:24] = rec_byte_i;
      default: word_nxt        = word_q;
    endcase
  end

  assign ram_we_o    = acc && store;
  assign ram_waddr_o = (bank_q ? AW'(WPB) : AW'(0)) + AW'(pos[7:2]);
  assign ram_wdata_o = word_nxt;

  // record descriptor and base update at the closing byte
  always_comb begin
    q_push_o          = acc && done;
    q_desc_o.is_data  = 1'b0;
    q_desc_o.kind     = KIND_ACCEPT;
    q_desc_o.bank     = bank_q;
    q_desc_o.base     = base_hi_q + {16'd0, off_q};
    q_desc_o.last_idx = len_m1[7:2];
    base_hi_d         = base_hi_q;
    bank_d            = bank_q;
    if (err) begin
      q_desc_o.kind = KIND_ERROR;
    end else if (type_q == REC_DATA) begin
      if (len_d != 8'd0) begin
        q_desc_o.is_data = 1'b1;
        q_desc_o.kind    = KIND_WRITE;
        bank_d           = !bank_q;
      end
    end else if (type_q == REC_EXT_SEG) begin
      base_hi_d = {12'd0, adat_q, 4'd0};
    end else if (type_q == REC_EXT_LIN) begin
      base_hi_d = {adat_q, 16'd0};
    end else begin
      base_hi_d = 32'd0;
    end
  end

  // bank occupancy
  always_comb begin
    busy_d = busy_q;
    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (q_push_o && q_desc_o.is_data) begin
      busy_d[bank_q] = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_idx_q <= '0;
      len_q      <= '0;
      sum_q      <= '0;
      base_hi_q  <= '0;
      bank_q     <= 1'b0;
      busy_q     <= '0;
    end else begin
      busy_q <= busy_d;
      if (acc) begin
        len_q <= len_d;
        sum_q <= sum_d;
        if (done) begin
          byte_idx_q <= '0;
          base_hi_q  <= base_hi_d;
          bank_q     <= bank_d;
        end else if (buffer_last_i) begin
          byte_idx_q <= '0;
        end else begin
          byte_idx_q <= idx_inc;
        end
      end
    end
  end

  // header fields and packing register
  always_ff @(posedge clk_i) begin
    if (acc) begin
      if (idx0) begin
        adat_q <= 16'd0;
      end
      if (byte_idx_q == 9'd1) begin
        off_q[15:8] <= rec_byte_i;
      end
      if (byte_idx_q == 9'd2) begin
        off_q[7:0] <= rec_byte_i;
      end
      if (byte_idx_q == 9'd3) begin
        type_q <= rec_byte_i;
      end
      if (is_data && pos == 9'd0) begin
        adat_q[15:8] <= rec_byte_i;
      end
      if (is_data && pos == 9'd1) begin
        adat_q[7:0] <= rec_byte_i;
      end
      if (is_data) begin
        word_q <= word_nxt;
      end
    end
  end

  // a bank is never filled while the back end still reads it
  a_no_fill_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> !busy_q[bank_q])
    else $error("front wrote into a busy bank");

  // only a held bank is released
  a_rel_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rel_i.valid |-> busy_q[rel_i.bank])
    else $error("release of a bank that is not held");

  // a data record leaves its bank held and switches banks
  a_data_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push_o && q_desc_o.is_data) |=> (busy_q[$past(bank_q)] && bank_q != $past(bank_q)))
    else $error("data record did not take its bank");

endmodule
`default_nettype wire

// ----- hw/rtl/hrfl_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrfl_back
// Takes record descriptors, reads the packed words of a data record, applies
// the address filter and pushes result items.
// ----------------------------------------------------------------------------
module hrfl_back #(
  parameter int MAX_DATA_BYTES = hrfl_pkg::MAX_DATA_BYTES_DEF,
  parameter int WPB            = (MAX_DATA_BYTES + 3) / 4,
  parameter int AW             = $clog2(2 * WPB)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire hrfl_pkg::cfg_t   cfg_i,
  input  wire hrfl_pkg::desc_t  q_desc_i,
  input  wire logic             q_empty_i,
  output      logic             q_pop_o,
  output      logic             ram_re_o,
  output      logic [AW-1:0]    ram_raddr_o,
  input  wire logic [31:0]      ram_rdata_i,
  output      logic             res_push_o,
  output      hrfl_pkg::res_t   res_o,
  input  wire logic             res_full_i,
  output      hrfl_pkg::rel_t   rel_o
);

  import hrfl_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT,
    ST_STATUS
  } state_e;

  state_e                state_q;
  desc_t                 desc_q;
  logic [LAST_IDX_W-1:0] idx_q;
  logic [31:0]           va_q;

  logic [31:0] va;
  logic        ok, last_word;

  // address filter on the current word
  assign va        = va_q | KSEG0_BIT;
  assign ok        = (va >= cfg_i.allow_low) && (va <= cfg_i.allow_high)
                  && !((va >= cfg_i.protect_low) && (va <= cfg_i.protect_high))
                  && !((va >= cfg_i.reserve_low) && (va <= cfg_i.reserve_high));
  assign last_word = (idx_q == desc_q.last_idx);

  assign q_pop_o     = (state_q == ST_IDLE) && !q_empty_i;
  assign ram_re_o    = (state_q == ST_READ);
  assign ram_raddr_o = (desc_q.bank ? AW'(WPB) : AW'(0)) + AW'(idx_q);

  // result selection
  always_comb begin
    res_push_o = 1'b0;
    res_o.kind = desc_q.kind;
    res_o.addr = 32'd0;
    res_o.data = 32'd0;
    res_o.last = 1'b1;
    case (state_q)
      ST_EMIT: begin
        res_push_o = !res_full_i;
        res_o.kind = ok ? KIND_WRITE : KIND_SKIP;
        res_o.addr = va;
        res_o.data = ram_rdata_i;
        res_o.last = last_word;
      end
      ST_STATUS: begin
        res_push_o = !res_full_i;
      end
      default: begin
        res_push_o = 1'b0;
      end
    endcase
  end

  assign rel_o.valid = (state_q == ST_EMIT) && !res_full_i && last_word;
  assign rel_o.bank  = desc_q.bank;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      desc_q  <= '0;
      idx_q   <= '0;
      va_q    <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            desc_q  <= q_desc_i;
            idx_q   <= '0;
            va_q    <= q_desc_i.base;
            state_q <= q_desc_i.is_data ? ST_READ : ST_STATUS;
          end
        end
        ST_READ: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!res_full_i) begin
            if (last_word) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q   <= idx_q + LAST_IDX_W'(1);
              va_q    <= va_q + 32'd4;
              state_q <= ST_READ;
            end
          end
        end
        ST_STATUS: begin
          if (!res_full_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // results are only pushed where the queue has room
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full queue");

  // every read is followed by its emit
  a_read_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |=> (state_q == ST_EMIT))
    else $error("word read without emit");

  // a status record yields a single final result
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && state_q == ST_STATUS) |-> (res_o.last && res_o.addr == 32'd0))
    else $error("status result malformed");

endmodule
`default_nettype wire

// ----- hw/rtl/hex_record_flash_loader_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hex_record_flash_loader_unit
// Intel HEX record loader with address filter for flash programming.
//
//   channel   direction  handshake                     payload
//   record    in         push / full                   rec_byte_i, buffer_last_i
//   result    out        pop / empty                   kind_o, word_address_o,
//                                                      word_data_o, last_o
//   config    in/out     psel, penable, pwrite, pready paddr, pwdata, prdata
//
// One record byte is taken per cycle while full is low. A data record
// yields its words in turn: the back end reads each from the RAM, which
// registers it, and emits it; a status record yields one result item.
// Two word banks let the next record fill while one drains; the input shows
// full while the bank to be filled is still draining or the record queue is
// full. Results stall the back end only, through the result queue.
// Reset is asynchronous; no clearing pass is needed, the word RAM is only
// read after being written within the same record.
// ----------------------------------------------------------------------------
module hex_record_flash_loader_unit #(
  parameter int MAX_DATA_BYTES = hrfl_pkg::MAX_DATA_BYTES_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push,
  output      logic                         full,
  input  wire logic [7:0]                   rec_byte_i,
  input  wire logic                         buffer_last_i,
  input  wire logic                         pop,
  output      logic                         empty,
  output      logic [1:0]                   kind_o,
  output      logic [31:0]                  word_address_o,
  output      logic [31:0]                  word_data_o,
  output      logic                         last_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [hrfl_pkg::PADDR_W-1:0] paddr,
  input  wire logic [hrfl_pkg::PDATA_W-1:0] pwdata,
  output      logic [hrfl_pkg::PDATA_W-1:0] prdata,
  output      logic                         pready
);

  import hrfl_pkg::*;

  localparam int WPB   = (MAX_DATA_BYTES + 3) / 4;
  localparam int DEPTH = 2 * WPB;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = $bits(desc_t);
  localparam int RW    = $bits(res_t);

  cfg_t          cfg_q;
  logic [2:0]    reg_idx;
  logic          cfg_wr;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;

  logic          q_push, q_full, q_pop, q_empty;
  desc_t         q_wdesc, q_rdesc;
  logic [DW-1:0] q_rdata;

  logic          res_push, res_full;
  res_t          res_w, res_r;
  logic [RW-1:0] res_rdata;
  rel_t          rel;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.allow_low    <= ALLOW_LOW_RST;
      cfg_q.allow_high   <= ALLOW_HIGH_RST;
      cfg_q.protect_low  <= PROTECT_LOW_RST;
      cfg_q.protect_high <= PROTECT_HIGH_RST;
      cfg_q.reserve_low  <= RESERVE_LOW_RST;
      cfg_q.reserve_high <= RESERVE_HIGH_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ALLOW_LOW:    cfg_q.allow_low    <= pwdata;
        REG_ALLOW_HIGH:   cfg_q.allow_high   <= pwdata;
        REG_PROTECT_LOW:  cfg_q.protect_low  <= pwdata;
        REG_PROTECT_HIGH: cfg_q.protect_high <= pwdata;
        REG_RESERVE_LOW:  cfg_q.reserve_low  <= pwdata;
        REG_RESERVE_HIGH: cfg_q.reserve_high <= pwdata;
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      REG_ALLOW_LOW:    prdata = cfg_q.allow_low;
      REG_ALLOW_HIGH:   prdata = cfg_q.allow_high;
      REG_PROTECT_LOW:  prdata = cfg_q.protect_low;
      REG_PROTECT_HIGH: prdata = cfg_q.protect_high;
      REG_RESERVE_LOW:  prdata = cfg_q.reserve_low;
      REG_RESERVE_HIGH: prdata = cfg_q.reserve_high;
      default:          prdata = '0;
    endcase
  end

  // record framing
  hrfl_front #(
    .MAX_DATA_BYTES (MAX_DATA_BYTES),
    .WPB            (WPB),
    .AW             (AW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .rec_byte_i    (rec_byte_i),
    .buffer_last_i (buffer_last_i),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .q_push_o      (q_push),
    .q_desc_o      (q_wdesc),
    .q_full_i      (q_full),
    .rel_i         (rel)
  );

  // two banks of packed data words
  hrfl_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // record queue between front and back
  hrfl_fifo #(
    .WIDTH (DW),
    .DEPTH (2)
  ) u_rec_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdesc),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  assign q_rdesc = desc_t'(q_rdata);

  // word generation and filtering
  hrfl_back #(
    .MAX_DATA_BYTES (MAX_DATA_BYTES),
    .WPB            (WPB),
    .AW             (AW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_desc_i    (q_rdesc),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .res_push_o  (res_push),
    .res_o       (res_w),
    .res_full_i  (res_full),
    .rel_o       (rel)
  );

  // result queue
  hrfl_fifo #(
    .WIDTH (RW),
    .DEPTH (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_w),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign res_r          = res_t'(res_rdata);
  assign kind_o         = res_r.kind;
  assign word_address_o = res_r.addr;
  assign word_data_o    = res_r.data;
  assign last_o         = res_r.last;

endmodule
`default_nettype wire
